// File: hdl/c3s_pkg.sv
// c3s_pkg: shared types, constants and the kernel function for the 3x3 sharpen stream.
// Used by every module under hdl; no dependencies.
`timescale 1ns / 1ps

package c3s_pkg;

  localparam int MAX_SIZE   = 1024;
  localparam int COL_W      = $clog2(MAX_SIZE);
  localparam int SIZE_W     = 11;
  localparam int PIX_W      = 8;
  localparam int VAL_W      = 12;
  localparam int TDATA_IN_W = 8;
  localparam int TDATA_OUT_W = 16;
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(512);
  localparam logic [SIZE_W-1:0] SIZE_MIN   = SIZE_W'(3);
  localparam logic [SIZE_W-1:0] SIZE_MAX   = SIZE_W'(MAX_SIZE);

  localparam logic [0:0] REG_IMAGE_SIZE = 1'b0;

  localparam logic [VAL_W-1:0] K_CENTRE = VAL_W'(5);

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [COL_W-1:0] col_idx_t;

  // one window column: rows r-2, r-1, r
  typedef struct packed {
    pix_t up;
    pix_t mid;
    pix_t cur;
  } win_col_t;

  // one line buffer word: row two above and row directly above
  typedef struct packed {
    pix_t up;
    pix_t mid;
  } line_t;

  function automatic logic [VAL_W-1:0] sharpen(input pix_t centre, input pix_t up,
                                               input pix_t down, input pix_t left,
                                               input pix_t right);
    logic [VAL_W-1:0] acc;
    acc = K_CENTRE * VAL_W'(centre);
    acc = acc - VAL_W'(up) - VAL_W'(down) - VAL_W'(left) - VAL_W'(right);
    return acc;
  endfunction

endpackage

// File: hdl/c3s_linebuf.sv
// c3s_linebuf: two line stores kept as one RAM of packed words, registered read.
// Depends on c3s_pkg.
`timescale 1ns / 1ps

module c3s_linebuf (
  input  logic             clk,
  input  logic             wr_en,
  input  c3s_pkg::col_idx_t wr_addr,
  input  c3s_pkg::line_t   wr_data,
  input  c3s_pkg::col_idx_t rd_addr,
  output c3s_pkg::line_t   rd_data
);
  import c3s_pkg::*;

  line_t mem [MAX_SIZE];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// File: hdl/c3s_cell.sv
// c3s_cell: one window cell holding a three-pixel column, shifted to its neighbor.
// Depends on c3s_pkg.
`timescale 1ns / 1ps

module c3s_cell (
  input  logic               clk,
  input  logic               rst,
  input  logic               shift,
  input  c3s_pkg::win_col_t  col_in,
  output c3s_pkg::win_col_t  col_out
);
  import c3s_pkg::*;

  win_col_t col;

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
    end else if (shift) begin
      col <= col_in;
    end
  end

  assign col_out = col;

endmodule

// File: hdl/c3s_out_stage.sv
// c3s_out_stage: kernel arithmetic and the output register of the master side.
// Depends on c3s_pkg.
`timescale 1ns / 1ps

module c3s_out_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  c3s_pkg::win_col_t  near_col,
  input  c3s_pkg::pix_t      left,
  input  c3s_pkg::pix_t      right,
  input  logic               last_in,
  input  logic               take,
  output logic               valid,
  output logic [c3s_pkg::VAL_W-1:0] value,
  output logic               last
);
  import c3s_pkg::*;

  logic valid_next;

  always_comb begin
    valid_next = valid;
    if (load) begin
      valid_next = 1'b1;
    end else if (take) begin
      valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      value <= sharpen(near_col.mid, near_col.up, near_col.cur, left, right);
      last  <= last_in;
    end
  end

endmodule

// File: hdl/conv3x3_sharpen_stream.sv
// conv3x3_sharpen_stream: top level, 3x3 sharpen convolution over a raster pixel stream.
// Depends on c3s_pkg, c3s_linebuf, c3s_cell, c3s_out_stage.
//
//   channel   dir   payload                         handshake
//   s_axis    in    tdata[7:0] pixel                tvalid/tready
//   m_axis    out   tdata[11:0] value, tlast        tvalid/tready
//   apb       in    reg 0 image_size at 0x0         psel/penable, pready=1
//
// One pixel per clock unless stalled; the result is valid in the cycle after its pixel.
// The line buffer RAM read is prefetched for the next column so its registered
// read never stalls the stream. Reset clears counters, window and output valid;
// line buffer contents stay undefined. Input stalls only when a result is
// pending and the pixel would produce another one.
`timescale 1ns / 1ps

module conv3x3_sharpen_stream (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [c3s_pkg::TDATA_IN_W-1:0]     s_tdata,   // [7:0] pixel
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [c3s_pkg::TDATA_OUT_W-1:0]    m_tdata,   // [11:0] value, [15:12] zero
  output logic                               m_tlast,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [c3s_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [c3s_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [c3s_pkg::APB_DATA_W-1:0]     prdata,
  output logic                               pready
);
  import c3s_pkg::*;

  logic [SIZE_W-1:0] image_size;
  logic [SIZE_W-1:0] size_eff;
  col_idx_t          size_m1;
  col_idx_t          row_count, row_count_next;
  col_idx_t          col_count, col_count_next;
  col_idx_t          rd_addr;
  logic              produce, col_wrap, row_wrap, accept;
  logic [VAL_W-1:0]  value;
  pix_t              pixel;
  line_t             rd_line, wr_line;
  win_col_t          cols [3];

  // configuration
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_size <= SIZE_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_IMAGE_SIZE) begin
      image_size <= pwdata[SIZE_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_IMAGE_SIZE) ? APB_DATA_W'(image_size) : '0;

  always_comb begin
    size_eff = image_size;
    if (image_size < SIZE_MIN) begin
      size_eff = SIZE_MIN;
    end else if (image_size > SIZE_MAX) begin
      size_eff = SIZE_MAX;
    end
  end

  assign size_m1 = COL_W'(size_eff - SIZE_W'(1));

  // position counters
  assign pixel    = s_tdata[PIX_W-1:0];
  assign produce  = (row_count >= COL_W'(2)) && (col_count >= COL_W'(2));
  assign col_wrap = col_count >= size_m1;
  assign row_wrap = row_count >= size_m1;
  assign s_tready = !produce || !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    row_count_next = row_count;
    col_count_next = col_count + COL_W'(1);
    if (col_wrap) begin
      col_count_next = '0;
      row_count_next = row_wrap ? '0 : row_count + COL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= '0;
      col_count <= '0;
    end else if (accept) begin
      row_count <= row_count_next;
      col_count <= col_count_next;
    end
  end

  // prefetch the column of the next pixel
  always_comb begin
    rd_addr = col_count;
    if (rst) begin
      rd_addr = '0;
    end else if (accept) begin
      rd_addr = col_count_next;
    end
  end

  assign wr_line.up  = rd_line.mid;
  assign wr_line.mid = pixel;

  c3s_linebuf u_linebuf (
    .clk     (clk),
    .wr_en   (accept),
    .wr_addr (col_count),
    .wr_data (wr_line),
    .rd_addr (rd_addr),
    .rd_data (rd_line)
  );

  // window chain: cols[2] is the incoming column, cols[1] is c-1, cols[0] is c-2
  assign cols[2].up  = rd_line.up;
  assign cols[2].mid = rd_line.mid;
  assign cols[2].cur = pixel;

  for (genvar i = 0; i < 2; i++) begin : g_cell
    c3s_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .shift   (accept),
      .col_in  (cols[i+1]),
      .col_out (cols[i])
    );
  end

  c3s_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (accept && produce),
    .near_col (cols[1]),
    .left     (cols[0].mid),
    .right    (rd_line.mid),
    .last_in  (row_wrap && col_wrap),
    .take     (m_tready),
    .valid    (m_tvalid),
    .value    (value),
    .last     (m_tlast)
  );

  assign m_tdata = TDATA_OUT_W'(value);

  // checks
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept && produce |=> m_tvalid)
    else $error("result missing after producing pixel");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !m_tready)
    else $error("input stalled without a pending result");

  a_col_wrap: assert property (@(posedge clk) disable iff (rst)
    accept && col_wrap |=> col_count == '0)
    else $error("column did not wrap");

  a_frame_end: assert property (@(posedge clk) disable iff (rst)
    accept && produce && row_wrap && col_wrap |=> row_count == '0 && col_count == '0 && m_tlast)
    else $error("frame end not marked or counters not cleared");

endmodule
